// ----- hw/rtl/fbpa_pkg.sv -----
// Package for the fixed block pool allocator.
// Holds sizes, codes and the payload and command types. No dependencies.
package fbpa_pkg;

	// Pool sizing
	localparam int MAX_BLOCKS = 256;
	localparam int INDEX_SPAN = 256;
	localparam int POOL_LIMIT = (MAX_BLOCKS > INDEX_SPAN) ? INDEX_SPAN : MAX_BLOCKS;
	localparam int STACK_AW   = $clog2(POOL_LIMIT);

	// Field widths
	localparam int BLK_W = 8;
	localparam int CNT_W = 9;
	localparam int TOT_W = 32;

	// Register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_NUM_BLOCKS = 1'b0;

	// Command queue between front and back
	localparam int CMD_DEPTH = 2;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);
	localparam int CMD_CW    = CMD_AW + 1;

	localparam logic [CNT_W-1:0] NUM_BLOCKS_RESET = CNT_W'(POOL_LIMIT);

	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_DROP  = 2'd2
	} op_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_POP  = 1'b1
	} bk_state_t;

	typedef struct packed {
		action_t            action;
		logic [BLK_W-1:0]   freed_block;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [BLK_W-1:0]   granted_block;
		logic [CNT_W-1:0]   free_count;
		logic [TOT_W-1:0]   allocated_total;
		logic [TOT_W-1:0]   released_total;
		logic [TOT_W-1:0]   failed_total;
	} rsp_t;

	typedef struct packed {
		op_t                op;
		logic [BLK_W-1:0]   blk;
	} cmd_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic               valid;
		cmd_t               cmd;
	} cmd_head_t;

endpackage

// ----- hw/rtl/fixed_block_pool_allocator_core.sv -----
// Top level of the fixed block pool allocator.
// Depends on fbpa_pkg, fbpa_front, fbpa_cmd_fifo and fbpa_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_stall| action, freed_block
//   rsp     | out       | rsp_valid/rsp_stall| status, granted_block, free_count,
//           |           |                    | allocated/released/failed totals
//   apb     | in        | psel/penable/pready| num_blocks at byte address 0
//
// A request enters a two-entry command queue the cycle it transfers, and the
// back end takes it in the cycle after at the earliest. A release, a failed
// allocation or a fresh-block grant loads the result as it is taken; an
// allocation served from the free stack passes through the registered stack read.
// The result register accepts a new result in the cycle the old one transfers.
// Reset clears the counters and stack depth; the stack memory is not cleared.
// Writing num_blocks clears the same state again.
module fixed_block_pool_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  fbpa_pkg::req_t                req,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output fbpa_pkg::rsp_t                rsp,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fbpa_pkg::APB_AW-1:0]   paddr,
	input  logic [fbpa_pkg::APB_DW-1:0]   pwdata,
	output logic [fbpa_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import fbpa_pkg::*;

	logic [CNT_W-1:0] num_blocks_q;
	logic [CNT_W-1:0] wr_value;
	logic             reg_sel;
	logic             cfg_wr;

	logic             q_full;
	logic             q_push;
	cmd_t             q_cmd;
	logic             q_pop;
	cmd_head_t        q_head;

	// Register port: always ready, one register, index in paddr above byte lanes
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1] == REG_NUM_BLOCKS);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? APB_DW'(num_blocks_q) : '0;

	// Clamp the written size: zero acts as one, above the limit saturates
	always_comb begin
		priority if (pwdata[CNT_W-1:0] == '0) begin
			wr_value = CNT_W'(1);
		end else if (pwdata[CNT_W-1:0] > CNT_W'(POOL_LIMIT)) begin
			wr_value = CNT_W'(POOL_LIMIT);
		end else begin
			wr_value = pwdata[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= NUM_BLOCKS_RESET;
		end else if (cfg_wr) begin
			num_blocks_q <= wr_value;
		end
	end

	// Classify and queue each transfer
	fbpa_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.num_blocks (num_blocks_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	fbpa_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	// Carry out commands against the free stack and counters
	fbpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_wr),
		.num_blocks (num_blocks_q),
		.head       (q_head),
		.cmd_pop    (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

// ----- hw/rtl/fbpa_front.sv -----
// Front end of the block pool allocator: takes requests and classifies them.
// Depends on fbpa_pkg.
module fbpa_front (
	input  logic                        req_valid,
	output logic                        req_stall,
	input  fbpa_pkg::req_t              req,
	input  logic [fbpa_pkg::CNT_W-1:0]  num_blocks,
	input  logic                        q_full,
	output logic                        q_push,
	output fbpa_pkg::cmd_t              q_cmd
);
	import fbpa_pkg::*;

	logic out_of_range;

	assign out_of_range = ({1'b0, req.freed_block} >= num_blocks);
	assign req_stall    = q_full;
	assign q_push       = req_valid && !q_full;

	always_comb begin
		q_cmd.blk = req.freed_block;
		unique case (req.action)
			ACT_ALLOC:   q_cmd.op = OP_ALLOC;
			ACT_RELEASE: q_cmd.op = out_of_range ? OP_DROP : OP_FREE;
			default:     q_cmd.op = OP_ALLOC;
		endcase
	end

endmodule

// ----- hw/rtl/fbpa_cmd_fifo.sv -----
// Short command queue between the allocator front and back ends.
// Depends on fbpa_pkg.
module fbpa_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fbpa_pkg::cmd_t      push_cmd,
	output logic                full,
	input  logic                pop,
	output fbpa_pkg::cmd_head_t head
);
	import fbpa_pkg::*;

	cmd_t              slot_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wr_ptr_q;
	logic [CMD_AW-1:0] rd_ptr_q;
	logic [CMD_CW-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == CMD_CW'(CMD_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMD_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_AW'(1);
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + CMD_CW'(1);
				2'b01:   count_q <= count_q - CMD_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/fbpa_back.sv -----
// Back end of the block pool allocator: free stack, counters, result register.
// Depends on fbpa_pkg.
module fbpa_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic [fbpa_pkg::CNT_W-1:0]  num_blocks,
	input  fbpa_pkg::cmd_head_t         head,
	output logic                        cmd_pop,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output fbpa_pkg::rsp_t              rsp
);
	import fbpa_pkg::*;

	bk_state_t          state_q, state_d;
	logic [CNT_W-1:0]   depth_q, depth_d;
	logic [CNT_W-1:0]   fresh_q, fresh_d;
	logic [TOT_W-1:0]   alloc_cnt_q, alloc_cnt_d;
	logic [TOT_W-1:0]   rel_cnt_q, rel_cnt_d;
	logic [TOT_W-1:0]   fail_cnt_q, fail_cnt_d;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [BLK_W-1:0]   stack_mem [POOL_LIMIT];
	logic [BLK_W-1:0]   rd_data_q;
	logic               rd_en, wr_en;
	logic [STACK_AW-1:0] rd_addr, wr_addr;

	logic               slot_free;
	logic               load;
	status_t            load_status;
	logic [BLK_W-1:0]   load_blk;
	logic [CNT_W:0]     free_now, free_next;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign cmd_pop   = head.valid && slot_free && (state_q == BK_IDLE);
	assign wr_addr   = depth_q[STACK_AW-1:0];
	assign rd_addr   = depth_d[STACK_AW-1:0];

	assign free_now  = {1'b0, depth_q} + ({1'b0, num_blocks} - {1'b0, fresh_q});
	assign free_next = {1'b0, depth_d} + ({1'b0, num_blocks} - {1'b0, fresh_d});

	always_comb begin
		state_d     = state_q;
		depth_d     = depth_q;
		fresh_d     = fresh_q;
		alloc_cnt_d = alloc_cnt_q;
		rel_cnt_d   = rel_cnt_q;
		fail_cnt_d  = fail_cnt_q;
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		load        = 1'b0;
		load_status = ST_OK;
		load_blk    = '0;
		unique case (state_q)
			BK_POP: begin
				// read data is back; the result slot was left empty at issue
				load     = 1'b1;
				load_blk = rd_data_q;
				state_d  = BK_IDLE;
			end
			BK_IDLE: begin
				if (cmd_pop) begin
					unique case (head.cmd.op)
						OP_ALLOC: begin
							priority if (depth_q != '0) begin
								depth_d     = depth_q - CNT_W'(1);
								rd_en       = 1'b1;
								alloc_cnt_d = alloc_cnt_q + TOT_W'(1);
								state_d     = BK_POP;
							end else if (fresh_q < num_blocks) begin
								load        = 1'b1;
								load_blk    = fresh_q[BLK_W-1:0];
								fresh_d     = fresh_q + CNT_W'(1);
								alloc_cnt_d = alloc_cnt_q + TOT_W'(1);
							end else begin
								load        = 1'b1;
								load_status = ST_EMPTY;
								fail_cnt_d  = fail_cnt_q + TOT_W'(1);
							end
						end
						OP_FREE: begin
							load = 1'b1;
							if (free_now >= {1'b0, num_blocks}) begin
								load_status = ST_BAD;
							end else begin
								wr_en     = 1'b1;
								depth_d   = depth_q + CNT_W'(1);
								rel_cnt_d = rel_cnt_q + TOT_W'(1);
							end
						end
						OP_DROP: begin
							load        = 1'b1;
							load_status = ST_BAD;
						end
						default: begin
							load        = 1'b1;
							load_status = ST_BAD;
						end
					endcase
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= head.cmd.blk;
		end
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.status          <= load_status;
			rsp_q.granted_block   <= load_blk;
			rsp_q.free_count      <= free_next[CNT_W-1:0];
			rsp_q.allocated_total <= alloc_cnt_d;
			rsp_q.released_total  <= rel_cnt_d;
			rsp_q.failed_total    <= fail_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			depth_q     <= '0;
			fresh_q     <= '0;
			alloc_cnt_q <= '0;
			rel_cnt_q   <= '0;
			fail_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else if (clear) begin
			state_q     <= BK_IDLE;
			depth_q     <= '0;
			fresh_q     <= '0;
			alloc_cnt_q <= '0;
			rel_cnt_q   <= '0;
			fail_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			depth_q     <= depth_d;
			fresh_q     <= fresh_d;
			alloc_cnt_q <= alloc_cnt_d;
			rel_cnt_q   <= rel_cnt_d;
			fail_cnt_q  <= fail_cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_pop_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_POP |-> !rsp_valid_q)
		else $error("stack pop pending while result slot occupied");

	a_pop_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_POP && !clear) |=> rsp_valid_q)
		else $error("stack pop did not produce a result");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= num_blocks)
		else $error("free stack deeper than the pool");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.free_count <= num_blocks)
		else $error("reported free count exceeds pool size");

endmodule

// ----- sim/tb_fixed_block_pool_allocator_core.sv -----
// Self-checking testbench for fixed_block_pool_allocator_core: allocate and release transfers
// with random idling on both channels, checked against a model of the pool stepped on each transfer.
// Depends on fbpa_pkg and the allocator RTL only.
module tb_fixed_block_pool_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpa_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 8;
	localparam int NUM_PHASES   = 11;

	// Block ports; the inputs are driven to known values from time zero
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [APB_AW-1:0]   paddr     = '0;
	logic [APB_DW-1:0]   pwdata    = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// Pool model: stack of released blocks, never-used pointer, totals
	logic [BLK_W-1:0]    freed_lifo [POOL_LIMIT];
	int unsigned         lifo_depth;
	int unsigned         fresh_idx;
	int unsigned         blocks_in_pool;
	logic [TOT_W-1:0]    grant_total;
	logic [TOT_W-1:0]    release_total;
	logic [TOT_W-1:0]    fail_total;

	// Stimulus and scoreboard stores
	req_t                req_backlog [$];
	rsp_t                owed_replies [$];
	rsp_t                oldest_reply;

	// Pacing of both channels
	bit                  burst_mode = 1'b0;
	bit                  drain_hold = 1'b0;
	int unsigned         gap_left   = 0;
	int unsigned         stall_left = 0;

	// Bookkeeping
	int unsigned         errors     = 0;
	int unsigned         sent_cnt   = 0;
	int unsigned         seen_cnt   = 0;
	int unsigned         ok_cnt     = 0;
	int unsigned         empty_cnt  = 0;
	int unsigned         refused_cnt = 0;
	int unsigned         cfg_writes = 0;
	int unsigned         cycle_cnt  = 0;

	fixed_block_pool_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Resize the model pool: only the low nine bits count, zero acts as one,
	// anything past the pool limit saturates. Empty the stack and clear totals.
	function automatic void reset_pool(logic [APB_DW-1:0] value);
		int unsigned sz;
		sz = 32'(value[CNT_W-1:0]);
		if (sz < 1)
			sz = 1;
		if (sz > POOL_LIMIT)
			sz = POOL_LIMIT;
		blocks_in_pool = sz;
		lifo_depth    = 0;
		fresh_idx     = 0;
		grant_total   = '0;
		release_total = '0;
		fail_total    = '0;
	endfunction

	// Advance the model by one request and return the reply it owes.
	function automatic rsp_t pool_step(req_t r);
		rsp_t        reply;
		int unsigned free_now;
		reply    = '0;
		reply.status = ST_OK;
		free_now = lifo_depth + (blocks_in_pool - fresh_idx);
		if (r.action == ACT_ALLOC) begin
			if (lifo_depth > 0) begin
				// most recently released block goes out first
				lifo_depth--;
				reply.granted_block = freed_lifo[lifo_depth];
				grant_total++;
			end else if (fresh_idx < blocks_in_pool) begin
				reply.granted_block = BLK_W'(fresh_idx);
				fresh_idx++;
				grant_total++;
			end else begin
				reply.status = ST_EMPTY;
				fail_total++;
			end
		end else if (free_now >= blocks_in_pool || r.freed_block >= blocks_in_pool) begin
			// pool already full or index outside the pool: drop
			reply.status = ST_BAD;
		end else begin
			// a block that is already free is taken back without complaint
			freed_lifo[lifo_depth] = r.freed_block;
			lifo_depth++;
			release_total++;
		end
		reply.free_count      = CNT_W'(lifo_depth + (blocks_in_pool - fresh_idx));
		reply.allocated_total = grant_total;
		reply.released_total  = release_total;
		reply.failed_total    = fail_total;
		return reply;
	endfunction

	function automatic void check_field(string field, logic [TOT_W-1:0] want,
	                                    logic [TOT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
			         $time, field, want, want, got, got);
			errors++;
		end
	endfunction

	function automatic void queue_req(action_t act, logic [BLK_W-1:0] blk);
		req_t item;
		item.action      = act;
		item.freed_block = blk;
		req_backlog.push_back(item);
	endfunction

	// Hold until the backlog is spent and every owed reply has transferred, then
	// let the back end settle before returning.
	task automatic wait_idle();
		while (req_backlog.size() != 0 || req_valid || owed_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Write num_blocks: setup cycle, then access cycle until pready. The register
	// takes the value at the edge where psel, penable, pwrite and pready are high.
	task automatic write_num_blocks(logic [APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * REG_NUM_BLOCKS);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reset_pool(value);
		cfg_writes++;
	endtask

	// Request driver: predict on every transfer, then either idle for the drawn
	// gap, hold off until all replies are in, or present the next request.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				owed_replies.push_back(pool_step(req));
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (drain_hold && owed_replies.size() != 0) begin
					req_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					req        <= req_backlog.pop_front();
					req_valid  <= 1'b1;
					gap_left   = burst_mode ? 0 : $urandom_range(0, 10);
					drain_hold = (sent_cnt == 40) || ($urandom_range(0, 49) == 0);
					sent_cnt++;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Reply monitor: compare each transfer with the oldest owed reply, then draw
	// how long to stall before taking the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				seen_cnt++;
				if (owed_replies.size() == 0) begin
					$display("%0t: reply with nothing owed, got 0x%0h", $time, rsp);
					errors++;
				end else begin
					oldest_reply = owed_replies.pop_front();
					check_field("status", TOT_W'(oldest_reply.status), TOT_W'(rsp.status));
					check_field("granted_block", TOT_W'(oldest_reply.granted_block),
					            TOT_W'(rsp.granted_block));
					check_field("free_count", TOT_W'(oldest_reply.free_count),
					            TOT_W'(rsp.free_count));
					check_field("allocated_total", oldest_reply.allocated_total,
					            rsp.allocated_total);
					check_field("released_total", oldest_reply.released_total,
					            rsp.released_total);
					check_field("failed_total", oldest_reply.failed_total, rsp.failed_total);
					case (oldest_reply.status)
						ST_OK:    ok_cnt++;
						ST_EMPTY: empty_cnt++;
						default:  refused_cnt++;
					endcase
				end
				stall_left = burst_mode ? 0 : $urandom_range(0, 10);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left > 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d replies owed", $time, owed_replies.size());
			$display("tb_fixed_block_pool_allocator_core NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned       pool_req [NUM_PHASES]  = '{511, 1, 2, 3, 7, 16, 300, 64, 5, 0, 256};
		int unsigned       phase_len [NUM_PHASES] = '{400, 80, 80, 80, 100, 100, 150, 150,
		                                              100, 60, 50};
		int unsigned       alloc_a [NUM_PHASES]   = '{90, 50, 60, 50, 70, 60, 50, 80, 50, 50, 60};
		int unsigned       alloc_b [NUM_PHASES]   = '{15, 50, 40, 50, 30, 40, 50, 20, 50, 50, 40};
		int unsigned       pct;
		logic [APB_DW-1:0] wval;
		req_t              item;

		reset_pool(APB_DW'(NUM_BLOCKS_RESET));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: full pool at its reset size, both index extremes, LIFO reuse
		queue_req(ACT_RELEASE, 8'd0);
		queue_req(ACT_RELEASE, 8'd255);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_RELEASE, 8'd255);
		queue_req(ACT_RELEASE, 8'd1);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		wait_idle();

		// Two blocks: exhaust, refuse out of range, double release, refuse when full
		write_num_blocks(32'd2);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_RELEASE, 8'd2);
		queue_req(ACT_RELEASE, 8'd255);
		queue_req(ACT_RELEASE, 8'd1);
		queue_req(ACT_RELEASE, 8'd1);
		queue_req(ACT_RELEASE, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		wait_idle();

		// Size zero behaves as a single block
		write_num_blocks(32'd0);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_ALLOC, 8'd0);
		queue_req(ACT_RELEASE, 8'd1);
		queue_req(ACT_RELEASE, 8'd0);
		queue_req(ACT_RELEASE, 8'd0);
		queue_req(ACT_ALLOC, 8'hFF);
		wait_idle();

		// Random phases, one pool size each. Most releases name a block inside
		// the pool; the rest are noise across the whole index range.
		for (int p = 0; p < NUM_PHASES; p++) begin
			wval = $urandom_range(0, 1) ? $urandom() : '0;
			wval[CNT_W-1:0] = CNT_W'(pool_req[p]);
			write_num_blocks(wval);
			burst_mode = (p == 3) || (p != 0 && $urandom_range(0, 4) == 0);
			for (int i = 0; i < phase_len[p]; i++) begin
				pct = (i < phase_len[p] / 2) ? alloc_a[p] : alloc_b[p];
				item.freed_block = BLK_W'($urandom_range(0, 255));
				if ($urandom_range(0, 99) < pct) begin
					item.action = ACT_ALLOC;
				end else begin
					item.action = ACT_RELEASE;
					if ($urandom_range(0, 9) != 0)
						item.freed_block = BLK_W'($urandom_range(0, blocks_in_pool - 1));
				end
				req_backlog.push_back(item);
			end
			wait_idle();
			burst_mode = 1'b0;
		end

		$display("Sent %0d requests across %0d register writes; %0d replies checked:",
		         sent_cnt, cfg_writes, seen_cnt);
		$display("  %0d ok, %0d empty-pool refusals, %0d dropped releases.",
		         ok_cnt, empty_cnt, refused_cnt);
		if (errors == 0 && owed_replies.size() == 0) begin
			$display("tb_fixed_block_pool_allocator_core OK");
		end else begin
			$display("tb_fixed_block_pool_allocator_core NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_front.sv
hw/rtl/fbpa_cmd_fifo.sv
hw/rtl/fbpa_back.sv
hw/rtl/fixed_block_pool_allocator_core.sv
sim/tb_fixed_block_pool_allocator_core.sv
